@@ rtl/ebec_pkg.sv @@
`timescale 1ns / 1ps

package ebec_pkg;

  localparam int unsigned TS_W      = 32;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned EVT_W     = 3;
  localparam int unsigned HIST_W    = 4;
  localparam int unsigned STEP_W    = 3;

  localparam logic [EVT_W-1:0] EV_NONE   = 3'd0;
  localparam logic [EVT_W-1:0] EV_CLICK  = 3'd1;
  localparam logic [EVT_W-1:0] EV_DOUBLE = 3'd2;
  localparam logic [EVT_W-1:0] EV_LONG   = 3'd3;
  localparam logic [EVT_W-1:0] EV_CW     = 3'd4;
  localparam logic [EVT_W-1:0] EV_CCW    = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_CLICK = 2'd1;

  localparam logic [CFG_W-1:0] LONG_PRESS_RST   = 16'd600;
  localparam logic [CFG_W-1:0] DOUBLE_CLICK_RST = 16'd300;

  localparam logic signed [STEP_W-1:0] STEP_FWD   = 3'sd1;
  localparam logic signed [STEP_W-1:0] STEP_BACK  = -3'sd1;
  localparam logic signed [STEP_W-1:0] STEP_ZERO  = 3'sd0;
  localparam logic signed [STEP_W-1:0] STEP_LIMIT = 3'sd2;

  typedef struct packed {
    logic            enc_a;
    logic            enc_b;
    logic            button_pressed;
    logic [TS_W-1:0] now_ms;
  } ebec_sample_t;

  typedef struct packed {
    logic [CFG_W-1:0] long_press_ms;
    logic [CFG_W-1:0] double_click_ms;
  } ebec_cfg_t;

  // Direction of one quadrature transition, given the previous and current A/B pairs.
  function automatic logic signed [STEP_W-1:0] quad_dir(input logic [HIST_W-1:0] h);
    logic signed [STEP_W-1:0] d;
    unique case (h)
      4'b1101, 4'b0100, 4'b0010, 4'b1011: d = STEP_FWD;
      4'b1110, 4'b0111, 4'b0001, 4'b1000: d = STEP_BACK;
      default:                            d = STEP_ZERO;
    endcase
    return d;
  endfunction

endpackage

@@ rtl/ebec_sample_if.sv @@
`timescale 1ns / 1ps

interface ebec_sample_if;
  logic                      valid;
  logic                      ready;
  logic                      enc_a;
  logic                      enc_b;
  logic                      button_pressed;
  logic [ebec_pkg::TS_W-1:0] now_ms;

  modport source (output valid, output enc_a, output enc_b, output button_pressed,
                  output now_ms, input ready);
  modport sink (input valid, input enc_a, input enc_b, input button_pressed,
                input now_ms, output ready);
endinterface

@@ rtl/ebec_event_if.sv @@
`timescale 1ns / 1ps

interface ebec_event_if;
  logic                       valid;
  logic                       ready;
  logic [ebec_pkg::EVT_W-1:0] event_code;

  modport source (output valid, output event_code, input ready);
  modport sink (input valid, input event_code, output ready);
endinterface

@@ rtl/ebec_cfg_if.sv @@
`timescale 1ns / 1ps

interface ebec_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ebec_pkg::CFG_IDX_W-1:0] index;
  logic [ebec_pkg::CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/ebec_classifier.sv @@
`timescale 1ns / 1ps

module ebec_classifier (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       fire,
  input  ebec_pkg::ebec_sample_t     sample,
  input  ebec_pkg::ebec_cfg_t        cfg,
  output logic [ebec_pkg::EVT_W-1:0] event_code
);
  import ebec_pkg::*;

  logic [HIST_W-1:0]        pin_history;
  logic signed [STEP_W-1:0] step_count;
  logic                     held;
  logic [TS_W-1:0]          press_start_ms;
  logic                     click_pending;
  logic [TS_W-1:0]          first_release_ms;

  logic [HIST_W-1:0]        pin_history_next;
  logic signed [STEP_W-1:0] step_sum;
  logic signed [STEP_W-1:0] step_count_next;
  logic                     held_next;
  logic [TS_W-1:0]          press_start_ms_next;
  logic                     click_pending_next;
  logic [TS_W-1:0]          first_release_ms_next;
  logic                     move_cw;
  logic                     move_ccw;
  logic                     done;
  logic [TS_W-1:0]          hold_time;
  logic [TS_W-1:0]          since_release;
  logic [TS_W-1:0]          since_release_mid;
  logic [TS_W-1:0]          long_lim;
  logic [TS_W-1:0]          dbl_lim;

  assign long_lim = {{(TS_W-CFG_W){1'b0}}, cfg.long_press_ms};
  assign dbl_lim  = {{(TS_W-CFG_W){1'b0}}, cfg.double_click_ms};

  assign pin_history_next = {pin_history[HIST_W-3:0], sample.enc_a, sample.enc_b};
  assign step_sum         = step_count + quad_dir(pin_history_next);
  assign move_cw          = (step_sum >= STEP_LIMIT);
  assign move_ccw         = (step_sum <= -STEP_LIMIT);
  assign hold_time        = sample.now_ms - press_start_ms;
  assign since_release    = sample.now_ms - first_release_ms;

  always_comb begin
    step_count_next       = (move_cw || move_ccw) ? STEP_ZERO : step_sum;
    held_next             = held;
    press_start_ms_next   = press_start_ms;
    click_pending_next    = click_pending;
    first_release_ms_next = first_release_ms;
    event_code            = EV_NONE;
    done                  = 1'b0;
    since_release_mid     = since_release;
    if (move_cw) begin
      event_code = EV_CW;
    end else if (move_ccw) begin
      event_code = EV_CCW;
    end else begin
      if (sample.button_pressed && !held) begin
        held_next           = 1'b1;
        press_start_ms_next = sample.now_ms;
      end
      if (!sample.button_pressed && held) begin
        held_next = 1'b0;
        if (hold_time > long_lim) begin
          event_code = EV_LONG;
          done       = 1'b1;
        end else if (click_pending && (since_release < dbl_lim)) begin
          click_pending_next = 1'b0;
          event_code         = EV_DOUBLE;
          done               = 1'b1;
        end else begin
          click_pending_next    = 1'b1;
          first_release_ms_next = sample.now_ms;
          since_release_mid     = '0;
        end
      end
      if (!done && click_pending_next && (since_release_mid > dbl_lim)) begin
        click_pending_next = 1'b0;
        event_code         = EV_CLICK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pin_history      <= '0;
      step_count       <= STEP_ZERO;
      held             <= 1'b0;
      press_start_ms   <= '0;
      click_pending    <= 1'b0;
      first_release_ms <= '0;
    end else if (fire) begin
      pin_history      <= pin_history_next;
      step_count       <= step_count_next;
      held             <= held_next;
      press_start_ms   <= press_start_ms_next;
      click_pending    <= click_pending_next;
      first_release_ms <= first_release_ms_next;
    end
  end

  // The step counter always rests between minus one and plus one.
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (step_count == STEP_ZERO) || (step_count == STEP_FWD) || (step_count == STEP_BACK))
    else $error("step counter outside its resting range");

  // A rotation leaves the button state untouched.
  a_rot_keeps_button: assert property (@(posedge clk) disable iff (rst)
    fire && (move_cw || move_ccw) |=> $stable(held) && $stable(click_pending))
    else $error("button state changed on a rotation sample");

  // A double click or a click consumes the pending click.
  a_click_clears: assert property (@(posedge clk) disable iff (rst)
    fire && ((event_code == EV_DOUBLE) || (event_code == EV_CLICK)) |=> !click_pending)
    else $error("pending click survived a click event");

endmodule

@@ rtl/encoder_and_button_event_classifier.sv @@
`timescale 1ns / 1ps

// Quadrature encoder and push-button event classifier.
// The samples channel carries one transaction per sample: encoder A/B levels, the
// button level and a free-running millisecond timestamp. Every sample gives exactly
// one transaction on the events channel, with an event code of none, click, double
// click, long press, clockwise or counter-clockwise.
// The cfg channel writes the long-press threshold (index 0) and the double-click
// window (index 1); it is always ready and should only be used while the block is idle.
// A sample is taken into an input register; its event is stored in the output register
// when it advances, which waits while an untaken event holds the output register.
// One sample per cycle is sustained while events are taken; the rate is set by the
// single pass through the classifier between the input and output registers.
// Reset clears the encoder history, step counter and button state, and loads the
// default thresholds of 600 ms and 300 ms.
// When the receiver stalls, the output register holds its event and the input register
// holds one more sample; samples.ready falls only when both are full.
module encoder_and_button_event_classifier (
  input  logic clk,
  input  logic rst,
  ebec_sample_if.sink  samples,
  ebec_event_if.source events,
  ebec_cfg_if.sink     cfg
);
  import ebec_pkg::*;

  logic               s1_valid;
  ebec_sample_t       s1_sample;
  logic               o_valid;
  logic [EVT_W-1:0]   o_event;
  logic               advance;
  logic [EVT_W-1:0]   core_event;
  ebec_cfg_t          cfg_regs;

  assign advance       = s1_valid && (!o_valid || events.ready);
  assign samples.ready = !s1_valid || advance;
  assign events.valid  = o_valid;
  assign events.event_code = o_event;
  assign cfg.ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (samples.valid && samples.ready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        o_valid <= 1'b1;
      end else if (events.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      s1_sample <= '{enc_a: samples.enc_a, enc_b: samples.enc_b,
                     button_pressed: samples.button_pressed, now_ms: samples.now_ms};
    end
    if (advance) begin
      o_event <= core_event;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.long_press_ms   <= LONG_PRESS_RST;
      cfg_regs.double_click_ms <= DOUBLE_CLICK_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_LONG_PRESS:   cfg_regs.long_press_ms   <= cfg.data;
        REG_DOUBLE_CLICK: cfg_regs.double_click_ms <= cfg.data;
        default: ;
      endcase
    end
  end

  ebec_classifier u_classifier (
    .clk        (clk),
    .rst        (rst),
    .fire       (advance),
    .sample     (s1_sample),
    .cfg        (cfg_regs),
    .event_code (core_event)
  );

  // Backpressure reaches the input only when both registers are occupied.
  a_ready_low_full: assert property (@(posedge clk) disable iff (rst)
    !samples.ready |-> s1_valid && o_valid && !events.ready)
    else $error("input stalled with a free register");

  // A sample leaving the input register always lands in the output register.
  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> o_valid)
    else $error("advanced sample lost");

  // An event that is not taken stays in place.
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    o_valid && !events.ready |=> o_valid && $stable(o_event))
    else $error("stalled event changed");

endmodule

@@ tb/encoder_and_button_event_classifier_tb.sv @@
`timescale 1ns / 1ps

module encoder_and_button_event_classifier_tb;
  import ebec_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int HOLD_CYCLES = 40;
  localparam int IDLE_LIMIT = 2000;
  localparam int PHASES = 7;
  localparam int ITEMS_PER_PHASE = 180;

  class event_scoreboard;
    logic [CFG_W-1:0]         long_press_ms = LONG_PRESS_RST;
    logic [CFG_W-1:0]         double_click_ms = DOUBLE_CLICK_RST;
    logic [HIST_W-1:0]        pin_history = '0;
    logic signed [STEP_W-1:0] step_count = STEP_ZERO;
    logic                     held = 1'b0;
    logic [TS_W-1:0]          press_start_ms = '0;
    logic                     click_pending = 1'b0;
    logic [TS_W-1:0]          first_release_ms = '0;
    logic [EVT_W-1:0]         expected_events[$];
    int                       failures = 0;

    function void write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] data);
      if (index == REG_LONG_PRESS) begin
        long_press_ms = data;
      end else if (index == REG_DOUBLE_CLICK) begin
        double_click_ms = data;
      end
    endfunction

    function logic [EVT_W-1:0] classify(input ebec_sample_t s);
      logic [EVT_W-1:0]         ev;
      logic                     done;
      logic signed [STEP_W-1:0] dir;
      ev = EV_NONE;
      done = 1'b0;
      pin_history = {pin_history[1:0], s.enc_a, s.enc_b};
      case (pin_history)
        4'b1101, 4'b0100, 4'b0010, 4'b1011: dir = 3'sd1;
        4'b1110, 4'b0111, 4'b0001, 4'b1000: dir = -3'sd1;
        default: dir = 3'sd0;
      endcase
      step_count = step_count + dir;
      if (step_count >= 3'sd2) begin
        step_count = STEP_ZERO;
        ev = EV_CW;
      end else if (step_count <= -3'sd2) begin
        step_count = STEP_ZERO;
        ev = EV_CCW;
      end else begin
        if (s.button_pressed && !held) begin
          held = 1'b1;
          press_start_ms = s.now_ms;
        end
        if (!s.button_pressed && held) begin
          held = 1'b0;
          if (TS_W'(s.now_ms - press_start_ms) > {16'd0, long_press_ms}) begin
            ev = EV_LONG;
            done = 1'b1;
          end else if (click_pending &&
                       TS_W'(s.now_ms - first_release_ms) < {16'd0, double_click_ms}) begin
            click_pending = 1'b0;
            ev = EV_DOUBLE;
            done = 1'b1;
          end else begin
            click_pending = 1'b1;
            first_release_ms = s.now_ms;
          end
        end
        if (!done && click_pending &&
            TS_W'(s.now_ms - first_release_ms) > {16'd0, double_click_ms}) begin
          click_pending = 1'b0;
          ev = EV_CLICK;
        end
      end
      return ev;
    endfunction

    function void note_sample(input ebec_sample_t s);
      expected_events.push_back(classify(s));
    endfunction

    function void check_event(input logic [EVT_W-1:0] code);
      logic [EVT_W-1:0] want;
      if (expected_events.size() == 0) begin
        $display("%0t: event with nothing expected, expected none, actual %0d", $time, code);
        failures++;
      end else begin
        want = expected_events.pop_front();
        if (code !== want) begin
          $display("%0t: event_code mismatch, expected %0d, actual %0d", $time, want, code);
          failures++;
        end
      end
    endfunction

    function int pending_count();
      return expected_events.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  ebec_sample_if samples();
  ebec_event_if  events();
  ebec_cfg_if    cfg();

  encoder_and_button_event_classifier dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .events  (events),
    .cfg     (cfg)
  );

  event_scoreboard sb;
  logic            steady = 1'b0;
  logic            hold_request = 1'b0;
  int              items_sent = 0;
  logic [TS_W-1:0] clock_ms = '0;
  int              enc_pos = 0;
  logic            btn_now = 1'b0;
  int              idle_cycles = 0;

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((samples.valid && samples.ready) || (events.valid && events.ready) ||
                 (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("encoder_and_button_event_classifier_tb failed");
        $finish;
      end
    end
  end

  initial begin
    int stall;
    events.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (hold_request) begin
        events.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      stall = steady ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        events.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      events.ready <= 1'b1;
      do @(posedge clk); while (!events.valid);
      sb.check_event(events.event_code);
    end
  end

  task automatic send_sample(input logic a, input logic b, input logic btn,
                             input logic [TS_W-1:0] t);
    ebec_sample_t s;
    int           gap;
    s.enc_a = a;
    s.enc_b = b;
    s.button_pressed = btn;
    s.now_ms = t;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      samples.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samples.valid <= 1'b1;
    samples.enc_a <= a;
    samples.enc_b <= b;
    samples.button_pressed <= btn;
    samples.now_ms <= t;
    do @(posedge clk); while (!samples.ready);
    sb.note_sample(s);
    items_sent++;
  endtask

  function automatic logic [1:0] gray_code(input int pos);
    case (pos % 4)
      0: return 2'b00;
      1: return 2'b10;
      2: return 2'b11;
      default: return 2'b01;
    endcase
  endfunction

  task automatic send_pos(input logic btn);
    logic [1:0] ab;
    ab = gray_code(enc_pos);
    send_sample(ab[1], ab[0], btn, clock_ms);
  endtask

  // Draws a span that is zero, lands on, just either side of, or somewhere around a threshold.
  function automatic logic [TS_W-1:0] near_threshold(input logic [CFG_W-1:0] thr);
    logic [TS_W-1:0] t;
    t = {16'd0, thr};
    case ($urandom_range(0, 7))
      0: return t - 1;
      1: return t;
      2: return t + 1;
      3: return '0;
      default: return $urandom_range(0, t + t / 2 + 2);
    endcase
  endfunction

  task automatic drain();
    samples.valid <= 1'b0;
    do @(posedge clk); while (sb.pending_count() != 0);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= index;
    cfg.data <= data;
    do @(posedge clk); while (!cfg.ready);
    sb.write_reg(index, data);
  endtask

  task automatic write_settings(input logic [CFG_W-1:0] long_ms, input logic [CFG_W-1:0] dbl_ms);
    cfg_write(REG_SPARE_A, CFG_W'($urandom()));
    cfg_write(REG_LONG_PRESS, long_ms);
    cfg_write(REG_DOUBLE_CLICK, dbl_ms);
    cfg_write(REG_SPARE_B, CFG_W'($urandom()));
    cfg.valid <= 1'b0;
  endtask

  task automatic random_episode();
    int              kind;
    int              n;
    int              dir;
    logic [TS_W-1:0] press_t;
    logic [TS_W-1:0] rel;
    logic [TS_W-1:0] gap;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1: begin
        n = $urandom_range(1, 6);
        dir = $urandom_range(0, 1) ? 1 : 3;
        repeat (n) begin
          enc_pos = (enc_pos + dir) % 4;
          if ($urandom_range(0, 3) == 0) btn_now = !btn_now;
          clock_ms += $urandom_range(0, 3);
          send_pos(btn_now);
        end
      end
      2, 3, 4, 5: begin
        btn_now = 1'b1;
        clock_ms += $urandom_range(1, 20);
        press_t = clock_ms;
        send_pos(1'b1);
        n = $urandom_range(0, 2);
        repeat (n) begin
          clock_ms += $urandom_range(0, sb.long_press_ms / 4 + 1);
          if ($urandom_range(0, 5) == 0) enc_pos = (enc_pos + 1) % 4;
          send_pos(1'b1);
        end
        clock_ms = press_t + near_threshold(sb.long_press_ms);
        btn_now = 1'b0;
        send_pos(1'b0);
        rel = clock_ms;
        if (kind >= 4) begin
          gap = near_threshold(sb.double_click_ms);
          clock_ms = rel + gap / 2;
          send_pos(1'b1);
          clock_ms = rel + gap;
          send_pos(1'b0);
        end
      end
      6, 7: begin
        n = $urandom_range(1, 3);
        repeat (n) begin
          clock_ms += near_threshold(sb.double_click_ms);
          send_pos(btn_now);
        end
      end
      8: begin
        enc_pos = $urandom_range(0, 3);
        btn_now = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 1)) clock_ms = $urandom();
        else clock_ms -= $urandom_range(0, 1000);
        send_pos(btn_now);
      end
      default: begin
        if ($urandom_range(0, 1)) enc_pos = (enc_pos + 2) % 4;
        clock_ms += $urandom_range(0, 50);
        send_pos(btn_now);
      end
    endcase
  endtask

  initial begin
    logic [CFG_W-1:0] long_tab[PHASES];
    logic [CFG_W-1:0] dbl_tab[PHASES];
    int               target;
    int               mid;
    logic             pressed_once;
    long_tab = '{LONG_PRESS_RST, 16'd0, 16'hFFFF, 16'd0, 16'd1, 16'hFFFF, 16'd0};
    dbl_tab = '{DOUBLE_CLICK_RST, 16'd0, 16'hFFFF, 16'd0, 16'd2, 16'd0, 16'hFFFF};
    long_tab[3] = CFG_W'($urandom_range(0, 65535));
    dbl_tab[3] = CFG_W'($urandom_range(0, 65535));
    sb = new();
    rst <= 1'b1;
    samples.valid <= 1'b0;
    samples.enc_a <= 1'b0;
    samples.enc_b <= 1'b0;
    samples.button_pressed <= 1'b0;
    samples.now_ms <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= REG_LONG_PRESS;
    cfg.data <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_sample(1'b0, 1'b0, 1'b0, 32'd0);
    send_sample(1'b1, 1'b0, 1'b0, 32'd1);
    send_sample(1'b1, 1'b1, 1'b0, 32'd2);
    send_sample(1'b0, 1'b1, 1'b0, 32'd3);
    send_sample(1'b0, 1'b0, 1'b0, 32'd4);
    send_sample(1'b0, 1'b1, 1'b0, 32'd5);
    send_sample(1'b1, 1'b1, 1'b0, 32'd6);
    send_sample(1'b0, 1'b0, 1'b0, 32'd7);
    send_sample(1'b0, 1'b0, 1'b1, 32'd10);
    send_sample(1'b0, 1'b0, 1'b0, 32'd100);
    send_sample(1'b0, 1'b0, 1'b0, 32'd401);
    send_sample(1'b0, 1'b0, 1'b1, 32'd1000);
    send_sample(1'b0, 1'b0, 1'b0, 32'd1050);
    send_sample(1'b0, 1'b0, 1'b1, 32'd1100);
    send_sample(1'b0, 1'b0, 1'b0, 32'd1349);
    send_sample(1'b0, 1'b0, 1'b1, 32'd3000);
    send_sample(1'b0, 1'b0, 1'b0, 32'd3010);
    send_sample(1'b0, 1'b0, 1'b1, 32'd3020);
    send_sample(1'b0, 1'b0, 1'b0, 32'd3700);
    send_sample(1'b0, 1'b0, 1'b0, 32'd3701);
    send_sample(1'b1, 1'b0, 1'b0, 32'd4000);
    send_sample(1'b1, 1'b1, 1'b1, 32'd4001);
    send_sample(1'b1, 1'b1, 1'b0, 32'd4002);
    send_sample(1'b1, 1'b1, 1'b1, 32'hFFFF_FFF0);
    send_sample(1'b1, 1'b1, 1'b0, 32'h0000_0010);
    send_sample(1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF);
    clock_ms = 32'hFFFF_FFFF;
    enc_pos = 2;
    btn_now = 1'b0;

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        drain();
        write_settings(long_tab[phase], dbl_tab[phase]);
      end
      steady = (phase == 2 || phase == 5);
      target = items_sent + ITEMS_PER_PHASE;
      mid = items_sent + ITEMS_PER_PHASE / 2;
      pressed_once = 1'b0;
      while (items_sent < target) begin
        random_episode();
        if (!pressed_once && items_sent >= mid) begin
          pressed_once = 1'b1;
          if (phase == 1 || phase == 4) hold_request = 1'b1;
          if (phase == 3) drain();
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.failures == 0 && sb.pending_count() == 0) begin
      $display("encoder_and_button_event_classifier_tb passed");
    end else begin
      $display("encoder_and_button_event_classifier_tb failed");
    end
    $finish;
  end

endmodule
